FILE: sv/double_ended_queue_engine_assert.svh
// ---------------------------------------------------------------------------
// Double-ended queue engine assertion macros
// Shared property macros for the checker of the queue engine.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DQE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqe assertion failed");

`endif

FILE: sv/dqe_pkg.sv
// ---------------------------------------------------------------------------
// Double-ended queue engine package
// Sizes, command and status codes, sequencer states and transaction types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

  localparam int IDX_W      = 6;
  localparam int DEPTH      = 2 ** IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_WIDTH = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_READ_INDEX = 3'd5,
    CMD_READ_LAST  = 3'd6
  } dqe_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } dqe_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDOUT,
    S_SCAN,
    S_SHIFT
  } dqe_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [DATA_WIDTH-1:0] data_word;
    logic [IDX_W-1:0]      position;
  } dqe_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result_word;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      occupancy;
  } dqe_out_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] data;
  } dqe_wr_t;

endpackage

`default_nettype wire

FILE: sv/double_ended_queue_engine.sv
// ---------------------------------------------------------------------------
// Double-ended queue engine
// Bounded deque in a ring store, driven by a small command sequencer.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and its single
// result appears on result with done high for exactly one cycle; the
// receiver cannot stall it, so it must take every result as it comes. Pushes
// and failing commands finish in the execute state, pops and reads pass
// through a readout state because the store has one registered read port,
// and remove by value scans and then shifts, since the same read port walks
// the entries one per cycle to find the match and then to move the later
// entries up. Busy falls in the cycle the result is shown.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire dqe_pkg::dqe_in_t  request,
  output logic                   done,
  output dqe_pkg::dqe_out_t      result
);
  import dqe_pkg::*;

  dqe_state_t            state, state_next;
  logic [IDX_W-1:0]      front, front_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [IDX_W-1:0]      idx, idx_next;
  dqe_in_t               req;
  logic                  emit;
  dqe_out_t              res_next;
  dqe_wr_t               wr;
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [CNT_W-1:0]      idx_p1, idx_p2;
  logic [IDX_W-1:0]      last_slot;

  dqe_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != S_IDLE);
  assign idx_p1    = {1'b0, idx} + CNT_W'(1);
  assign idx_p2    = {1'b0, idx} + CNT_W'(2);
  assign last_slot = front + count[IDX_W-1:0] - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (start && !busy) begin
      req <= request;
    end
    if (emit) begin
      result <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    emit       = 1'b0;
    res_next   = '0;
    wr         = '0;
    rd_addr    = front;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req.cmd)
          CMD_PUSH_FRONT: begin
            emit = 1'b1;
            if (count == CNT_W'(DEPTH)) begin
              res_next.status = ST_FULL;
            end else begin
              front_next      = front - IDX_W'(1);
              count_next      = count + CNT_W'(1);
              wr.en           = 1'b1;
              wr.addr         = front - IDX_W'(1);
              wr.data         = req.data_word;
              res_next.status = ST_OK;
            end
          end
          CMD_PUSH_BACK: begin
            emit = 1'b1;
            if (count == CNT_W'(DEPTH)) begin
              res_next.status = ST_FULL;
            end else begin
              count_next      = count + CNT_W'(1);
              wr.en           = 1'b1;
              wr.addr         = front + count[IDX_W-1:0];
              wr.data         = req.data_word;
              res_next.status = ST_OK;
            end
          end
          CMD_POP_FRONT: begin
            if (count == '0) begin
              emit            = 1'b1;
              res_next.status = ST_MISS;
            end else begin
              rd_addr    = front;
              state_next = S_RDOUT;
            end
          end
          CMD_POP_BACK, CMD_READ_LAST: begin
            if (count == '0) begin
              emit            = 1'b1;
              res_next.status = ST_MISS;
            end else begin
              rd_addr    = last_slot;
              state_next = S_RDOUT;
            end
          end
          CMD_READ_INDEX: begin
            if ({1'b0, req.position} >= count) begin
              emit            = 1'b1;
              res_next.status = ST_MISS;
            end else begin
              rd_addr    = front + req.position;
              state_next = S_RDOUT;
            end
          end
          CMD_REMOVE: begin
            if (count == '0) begin
              emit            = 1'b1;
              res_next.status = ST_MISS;
            end else begin
              idx_next   = '0;
              rd_addr    = front;
              state_next = S_SCAN;
            end
          end
          default: begin
            emit            = 1'b1;
            res_next.status = ST_MISS;
          end
        endcase
      end

      S_RDOUT: begin
        emit                 = 1'b1;
        res_next.result_word = rd_data;
        res_next.status      = ST_OK;
        case (req.cmd)
          CMD_POP_FRONT: begin
            front_next = front + IDX_W'(1);
            count_next = count - CNT_W'(1);
          end
          CMD_POP_BACK: begin
            count_next = count - CNT_W'(1);
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (idx_p1 < count) begin
          rd_addr = front + idx_p1[IDX_W-1:0];
        end
        if (rd_data == req.data_word) begin
          if (idx_p1 < count) begin
            state_next = S_SHIFT;
          end else begin
            count_next      = count - CNT_W'(1);
            emit            = 1'b1;
            res_next.status = ST_OK;
          end
        end else if (idx_p1 < count) begin
          idx_next = idx_p1[IDX_W-1:0];
        end else begin
          emit            = 1'b1;
          res_next.status = ST_MISS;
        end
      end

      S_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = front + idx;
        wr.data = rd_data;
        if (idx_p2 < count) begin
          rd_addr  = front + idx_p2[IDX_W-1:0];
          idx_next = idx_p1[IDX_W-1:0];
        end else begin
          count_next      = count - CNT_W'(1);
          emit            = 1'b1;
          res_next.status = ST_OK;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.occupancy = count_next;
    if (emit) begin
      state_next = S_IDLE;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dqe_store.sv
// ---------------------------------------------------------------------------
// Queue entry store
// Ring storage with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqe_store (
  input  wire logic                          clk,
  input  wire dqe_pkg::dqe_wr_t              wr,
  input  wire logic [dqe_pkg::IDX_W-1:0]     rd_addr,
  output logic      [dqe_pkg::DATA_WIDTH-1:0] rd_data
);
  import dqe_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/dqe_checker.sv
// ---------------------------------------------------------------------------
// Double-ended queue engine checker
// Port-level checks on the command handshake and the result strobe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_engine_assert.svh"

module dqe_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire dqe_pkg::dqe_out_t result
);
  import dqe_pkg::*;

  `DQE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `DQE_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `DQE_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `DQE_ASSERT_SAME(a_occ_range, clk, rst, done, result.occupancy <= CNT_W'(DEPTH))
  `DQE_ASSERT_SAME(a_status_code, clk, rst, done, result.status <= ST_FULL)

endmodule

bind double_ended_queue_engine dqe_checker u_dqe_checker (.*);

`default_nettype wire
